// File: rtl/pulse_duration_to_symbol_packer_assert.svh
// Assertion macros shared by the packer RTL.
`ifndef PULSE_DURATION_TO_SYMBOL_PACKER_ASSERT_SVH
`define PULSE_DURATION_TO_SYMBOL_PACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PDSP_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("packer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PDSP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("packer assertion failed");

`endif

// File: rtl/pdsp_pkg.sv
`timescale 1ns / 1ps
package pdsp_pkg;

  localparam int DUR_W = 21;
  localparam int MAG_W = 20;
  localparam int LEN_W = 15;
  localparam int MAX_WORDS = 17;
  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef struct packed {
    logic             level_a;
    logic [LEN_W-1:0] length_a;
    logic             level_b;
    logic [LEN_W-1:0] length_b;
    logic             word_last;
  } word_t;

endpackage

// File: rtl/pulse_duration_to_symbol_packer.sv
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid/in_ready    duration[20:0] signed, frame_end
// out      out_valid/out_ready  level_a, length_a[14:0], level_b, length_b[14:0], word_last
//
// An item is accepted while in_ready is high, then is cut into chunks of at
// most MAX_CHUNK ticks, one run step per chunk, plus a flush step when a
// frame end finds a held half. One shared chunk compare and subtract unit
// serves every run step; in_ready is low until the item is finished.
// Steps that emit a word wait while the output register holds an untaken word.
// Reset clears the pairing state, the sequencer and the output valid flag.
module pulse_duration_to_symbol_packer
  import pdsp_pkg::*;
#(
  parameter int MAX_CHUNK = 32767
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DUR_W-1:0] duration,
  input  logic                    frame_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    level_a,
  output logic [LEN_W-1:0]        length_a,
  output logic                    level_b,
  output logic [LEN_W-1:0]        length_b,
  output logic                    word_last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state;
  logic [MAG_W-1:0] mag;
  logic             level;
  logic             frame_end_r;
  logic [CNT_W-1:0] count;
  logic             half_pending;
  logic             pending_level;
  logic [LEN_W-1:0] pending_length;

  // Magnitude and level of the incoming duration, formed at acceptance.
  logic [DUR_W-1:0] neg_mag;
  logic [MAG_W-1:0] in_mag;
  logic             in_level;

  always_comb begin
    neg_mag  = DUR_W'(-duration);
    in_level = !duration[DUR_W-1] && (duration != '0);
    if (duration[DUR_W-1]) begin
      // The most negative value has a magnitude one past the range; clamp it.
      in_mag = neg_mag[DUR_W-1] ? MAG_MAX : neg_mag[MAG_W-1:0];
    end else if (duration == '0) begin
      // A zero duration counts as a low pulse of one tick.
      in_mag = MAG_W'(1);
    end else begin
      in_mag = duration[MAG_W-1:0];
    end
  end

  // Shared chunk unit works on the remaining magnitude every run cycle.
  logic [LEN_W-1:0] chunk;
  logic [MAG_W-1:0] rem;
  logic             rem_zero;

  pdsp_chunk #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_chunk (
    .mag     (mag),
    .chunk   (chunk),
    .rem     (rem),
    .rem_zero(rem_zero)
  );

  // Output register.
  logic  out_free;
  logic  load;
  word_t word_in;
  word_t word_out;

  pdsp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .word_in  (word_in),
    .free     (out_free),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .word_out (word_out)
  );

  assign level_a   = word_out.level_a;
  assign length_a  = word_out.length_a;
  assign level_b   = word_out.level_b;
  assign length_b  = word_out.length_b;
  assign word_last = word_out.word_last;

  assign in_ready = (state == ST_IDLE);

  // Words past the per-item limit are dropped, but pairing still advances.
  logic room;
  logic step;

  assign room = (count < CNT_W'(MAX_WORDS));

  always_comb begin
    step    = 1'b0;
    load    = 1'b0;
    word_in = '0;
    unique case (state)
      ST_RUN: begin
        // A store step never waits; an emit step needs the output slot.
        step = !half_pending || out_free || !room;
        load = step && half_pending && room;
        word_in.level_a   = pending_level;
        word_in.length_a  = pending_length;
        word_in.level_b   = level;
        word_in.length_b  = chunk;
        // With a frame end, this word is last if it closes the item or fills
        // the per-item limit.
        word_in.word_last = frame_end_r &&
                            (rem_zero || (count == CNT_W'(MAX_WORDS - 1)));
      end
      ST_FLUSH: begin
        step = out_free || !room;
        load = step && room;
        word_in.level_a   = pending_level;
        word_in.length_a  = pending_length;
        word_in.level_b   = pending_level;
        word_in.length_b  = '0;
        word_in.word_last = 1'b1;
      end
      default: begin
        step = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      half_pending   <= 1'b0;
      pending_level  <= 1'b0;
      pending_length <= '0;
      count          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
            count <= '0;
          end
        end
        ST_RUN: begin
          if (step) begin
            if (half_pending) begin
              half_pending <= 1'b0;
              if (room) begin
                count <= count + CNT_W'(1);
              end
            end else begin
              half_pending   <= 1'b1;
              pending_level  <= level;
              pending_length <= chunk;
            end
            if (rem_zero) begin
              // A half stored on the final chunk must be flushed at frame end.
              state <= (frame_end_r && !half_pending) ? ST_FLUSH : ST_IDLE;
            end
          end
        end
        ST_FLUSH: begin
          if (step) begin
            half_pending <= 1'b0;
            state        <= ST_IDLE;
            if (room) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      mag         <= in_mag;
      level       <= in_level;
      frame_end_r <= frame_end;
    end else if (state == ST_RUN && step) begin
      mag <= rem;
    end
  end

`include "pulse_duration_to_symbol_packer_assert.svh"

  // A zero second half only comes from a flush, which always closes the frame.
  `PDSP_ASSERT_SAME(a_flush_marked, clk, rst, out_valid && (length_b == '0), word_last)
  // An accepted item closes the input side in the next cycle.
  `PDSP_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // The flush step only runs with a half held.
  `PDSP_ASSERT_SAME(a_flush_has_half, clk, rst, state == ST_FLUSH, half_pending)

endmodule

// File: rtl/pdsp_chunk.sv
`timescale 1ns / 1ps
module pdsp_chunk
  import pdsp_pkg::*;
#(
  parameter int MAX_CHUNK = 32767
) (
  input  logic [MAG_W-1:0] mag,
  output logic [LEN_W-1:0] chunk,
  output logic [MAG_W-1:0] rem,
  output logic             rem_zero
);

  localparam logic [MAG_W-1:0] CHUNK_CAP = MAG_W'(MAX_CHUNK);

  // One compare picks the chunk, one subtract leaves the remainder.
  always_comb begin
    if (mag > CHUNK_CAP) begin
      chunk = LEN_W'(MAX_CHUNK);
    end else begin
      chunk = mag[LEN_W-1:0];
    end
    rem      = mag - MAG_W'(chunk);
    rem_zero = (rem == '0);
  end

endmodule

// File: rtl/pdsp_out_reg.sv
`timescale 1ns / 1ps
module pdsp_out_reg
  import pdsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  word_t word_in,
  output logic  free,
  input  logic  out_ready,
  output logic  out_valid,
  output word_t word_out
);

  // The slot can take a new word when empty or when its word leaves now.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_out <= word_in;
    end
  end

endmodule

// File: tb/sv/symbol_word_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the packer. Every accepted duration is run through
// a local copy of the chunking and pairing rules. The symbol words that it
// yields are queued, and each word that leaves the block is compared against
// the oldest queued word.
module symbol_word_checker
  import pdsp_pkg::*;
#(
  parameter int MAX_CHUNK = 32767
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [DUR_W-1:0] duration,
  input  logic                    frame_end,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    level_a,
  input  logic [LEN_W-1:0]        length_a,
  input  logic                    level_b,
  input  logic [LEN_W-1:0]        length_b,
  input  logic                    word_last,
  output int                      mismatches,
  output int                      words_waiting,
  output int                      words_seen
);

  word_t            words_due[$];
  logic             hold_valid;
  logic             hold_level;
  logic [LEN_W-1:0] hold_len;
  int               fail_count;
  int               seen_count;

  task automatic report_mismatch(input string what);
    begin
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
    end
  endtask

  task automatic compare_field(input string field, input int got, input int want);
    begin
      if (got != want) begin
        report_mismatch($sformatf("word %0d %s is %0d, expected %0d", seen_count, field,
                                  got, want));
      end
    end
  endtask

  // Cuts one duration into chunks, pairs them with the held half, and queues
  // the resulting words. A duration keeps at most MAX_WORDS words; any surplus is
  // dropped, although the pairing state still moves on.
  task automatic pack_duration(input logic signed [DUR_W-1:0] dur, input logic fe);
    word_t batch[MAX_WORDS];
    int    made;
    int    mag;
    int    piece;
    logic  lvl;
    begin
      made = 0;
      lvl  = (dur > 0);
      mag  = (dur < 0) ? -int'(dur) : int'(dur);
      if (mag == 0) mag = 1;
      if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
      while (mag > 0) begin
        piece = (mag > MAX_CHUNK) ? MAX_CHUNK : mag;
        if (hold_valid) begin
          if (made < MAX_WORDS) begin
            batch[made] = '{hold_level, hold_len, lvl, LEN_W'(piece), 1'b0};
            made++;
          end
          hold_valid = 1'b0;
        end else begin
          hold_level = lvl;
          hold_len   = LEN_W'(piece);
          hold_valid = 1'b1;
        end
        mag -= piece;
      end
      if (fe) begin
        // The flushed half keeps its own level and gets a zero-length partner.
        if (hold_valid) begin
          if (made < MAX_WORDS) begin
            batch[made] = '{hold_level, hold_len, hold_level, '0, 1'b0};
            made++;
          end
          hold_valid = 1'b0;
        end
        if (made > 0) batch[made-1].word_last = 1'b1;
      end
      for (int i = 0; i < made; i++) words_due.push_back(batch[i]);
    end
  endtask

  always @(posedge clk) begin
    word_t want;
    if (rst) begin
      words_due.delete();
      hold_valid = 1'b0;
      hold_level = 1'b0;
      hold_len   = '0;
      fail_count = 0;
      seen_count = 0;
    end else begin
      if (in_valid && in_ready) pack_duration(duration, frame_end);
      if (out_valid && out_ready) begin
        if (words_due.size() == 0) begin
          report_mismatch("symbol word arrived with none expected");
        end else begin
          want = words_due.pop_front();
          compare_field("level_a", level_a, want.level_a);
          compare_field("length_a", length_a, want.length_a);
          compare_field("level_b", level_b, want.level_b);
          compare_field("length_b", length_b, want.length_b);
          compare_field("word_last", word_last, want.word_last);
        end
        seen_count++;
      end
    end
    mismatches    <= fail_count;
    words_waiting <= words_due.size();
    words_seen    <= seen_count;
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the packer bench. This module only creates stimulus and calls the
// verdict; all prediction and comparison lives in the checker beside the DUT.
//
// The run has three parts:
//   1. A directed list that hits the sign rules, the zero and saturation
//      cases, the chunk boundaries, and both flavors of frame end (with a
//      held half to flush and without one).
//   2. A pressure stretch, in which the receiver holds off for a long time
//      while the sender keeps offering items, so that the output register
//      fills up and the input side has to stall.
//   3. A long random part. Half the magnitudes are small, with weight on the
//      chunk boundaries, and a few full-width and extreme values.
// Inputs are driven on the falling edge and everything is sampled on the
// rising edge, so no check depends on event ordering within a time step.
module testbench;
  import pdsp_pkg::*;

  localparam int CHUNK_TICKS = 32767;
  localparam int HOLD_CYCLES = 300;
  localparam logic signed [DUR_W-1:0] DUR_MIN = {1'b1, {(DUR_W-1){1'b0}}};
  localparam logic signed [DUR_W-1:0] DUR_MAX = {1'b0, {(DUR_W-1){1'b1}}};

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [DUR_W-1:0] duration;
  logic                    frame_end;
  logic                    out_valid;
  logic                    out_ready;
  logic                    level_a;
  logic [LEN_W-1:0]        length_a;
  logic                    level_b;
  logic [LEN_W-1:0]        length_b;
  logic                    word_last;

  int mismatches;
  int words_waiting;
  int words_seen;

  // Shared knobs: idle_on allows random idle bursts on both sides, and
  // hold_request asks the receiver for one long hold-off.
  bit idle_on;
  bit hold_request;
  int items_sent;
  int frames_sent;

  pulse_duration_to_symbol_packer #(
    .MAX_CHUNK(CHUNK_TICKS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .duration (duration),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .level_a  (level_a),
    .length_a (length_a),
    .level_b  (level_b),
    .length_b (length_b),
    .word_last(word_last)
  );

  symbol_word_checker #(
    .MAX_CHUNK(CHUNK_TICKS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .duration     (duration),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .level_a      (level_a),
    .length_a     (length_a),
    .level_b      (level_b),
    .length_b     (length_b),
    .word_last    (word_last),
    .mismatches   (mismatches),
    .words_waiting(words_waiting),
    .words_seen   (words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver. Outside of the long hold-off it stalls in short random bursts
  // while idling is allowed, and otherwise takes every word right away.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns once it has been accepted. Valid stays high
  // into the next item unless an idle gap lowers it.
  task automatic send_item(input logic signed [DUR_W-1:0] dur, input logic fe);
    begin
      @(negedge clk);
      in_valid  <= 1'b1;
      duration  <= dur;
      frame_end <= fe;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      items_sent++;
      if (fe) frames_sent++;
    end
  endtask

  // Now and then drops valid for a random burst while idling is allowed.
  task automatic idle_gap();
    begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end
    end
  endtask

  // Half short pulses, a good share near multiples of the chunk size, and
  // some full-width and extreme values so every duration bit toggles.
  function automatic logic signed [DUR_W-1:0] pick_duration();
    int                      sel;
    int                      mag;
    logic signed [DUR_W-1:0] dur;
    begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        mag = $urandom_range(0, 100);
      end else if (sel < 70) begin
        mag = CHUNK_TICKS * $urandom_range(1, 3) + $urandom_range(0, 8) - 4;
      end else if (sel < 85) begin
        mag = $urandom_range(0, 200000);
      end else if (sel < 95) begin
        return DUR_W'($urandom());
      end else begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return DUR_MIN;
          default: return DUR_MAX;
        endcase
      end
      dur = DUR_W'(mag);
      return ($urandom_range(0, 1) == 1) ? -dur : dur;
    end
  endfunction

  initial begin
    int                      n;
    logic signed [DUR_W-1:0] dur;

    rst          = 1'b1;
    in_valid     = 1'b0;
    duration     = '0;
    frame_end    = 1'b0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    items_sent   = 0;
    frames_sent  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Zero is a one-tick low pulse; single ticks of each sign.
    idle_gap(); send_item('0, 1'b0);
    idle_gap(); send_item(DUR_W'(1), 1'b0);
    idle_gap(); send_item(DUR_W'(-1), 1'b0);
    // Exactly one chunk, and one tick past it, for both levels.
    idle_gap(); send_item(DUR_W'(CHUNK_TICKS), 1'b0);
    idle_gap(); send_item(DUR_W'(CHUNK_TICKS + 1), 1'b0);
    idle_gap(); send_item(DUR_W'(-CHUNK_TICKS), 1'b0);
    idle_gap(); send_item(DUR_W'(-(CHUNK_TICKS + 1)), 1'b1);
    // Largest positive value closes a frame.
    idle_gap(); send_item(DUR_MAX, 1'b1);
    // Most negative value saturates; alone it leaves a half to flush.
    idle_gap(); send_item(DUR_MIN, 1'b1);
    idle_gap(); send_item(-DUR_MAX, 1'b0);
    idle_gap(); send_item(DUR_W'(2 * CHUNK_TICKS), 1'b1);
    // Frame end with a held half: odd number of halves before the flush.
    idle_gap(); send_item(DUR_W'(5), 1'b1);
    // Frame end with nothing held: the pairing word itself is marked.
    idle_gap(); send_item(DUR_W'(7), 1'b0);
    idle_gap(); send_item(DUR_W'(9), 1'b1);
    // A zero duration that ends a frame on its own.
    idle_gap(); send_item('0, 1'b1);
    // A held half followed by a saturated pulse gives the longest step.
    idle_gap(); send_item(DUR_W'(4), 1'b0);
    idle_gap(); send_item(DUR_MAX, 1'b1);
    idle_gap(); send_item(DUR_W'(-3), 1'b0);
    idle_gap(); send_item(DUR_MIN, 1'b1);
    idle_gap(); send_item(DUR_W'(-100000), 1'b0);
    idle_gap(); send_item(DUR_W'(12345), 1'b1);

    // Pressure: the receiver stops for a long stretch while items keep
    // coming back to back, so the block has to hold off its input.
    hold_request = 1'b1;
    for (n = 0; n < 20; n++) begin
      dur = pick_duration();
      send_item(dur, ($urandom_range(0, 3) == 0));
    end

    // Random part, in blocks that switch idling on or off; the final block
    // runs with no idling at all.
    for (n = 0; n < 340; n++) begin
      if (n % 40 == 0) idle_on = (n < 300) && ($urandom_range(0, 3) != 0);
      idle_gap();
      dur = pick_duration();
      send_item(dur, ($urandom_range(0, 3) == 0));
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every predicted word, then linger long enough to catch
    // a stray word from the longest possible step.
    repeat (2) @(posedge clk);
    for (n = 0; n < 100000 && words_waiting != 0; n++) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Drove %0d durations over %0d frame ends; %0d symbol words compared.",
             items_sent, frames_sent, words_seen);
    $display("Covered zero and saturated pulses, chunk boundaries, flushes and a long stall.");
    if (words_waiting != 0) begin
      $display("%0d predicted symbol words never arrived", words_waiting);
    end
    if (mismatches == 0 && words_waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: pulse_duration_to_symbol_packer.f
+incdir+rtl
rtl/pdsp_pkg.sv
rtl/pdsp_chunk.sv
rtl/pdsp_out_reg.sv
rtl/pulse_duration_to_symbol_packer.sv
tb/sv/symbol_word_checker.sv
tb/sv/testbench.sv
